// File: design/erm_pkg.sv
// Shared types, constants and the status classifier of the event rate monitor.
// No dependencies.
package erm_pkg;

    // Default sizing of the top level
    localparam int unsigned WINDOW_DEPTH_DEF = 16;
    localparam int unsigned COUNT_WIDTH_DEF  = 24;

    // One second in microseconds, scaled by 2^8 for the Q24.8 result
    localparam int unsigned         Q8_W  = 28;
    localparam logic [Q8_W-1:0]     US_Q8 = 28'd256000000;

    typedef enum logic [1:0] {
        ST_RED    = 2'd0,
        ST_YELLOW = 2'd1,
        ST_GREEN  = 2'd2
    } t_status;

    // green above 0.9x desired, yellow above 0.5x, red otherwise
    function automatic t_status status_of(logic [31:0] avg, logic [31:0] des);
        logic [35:0] a10;
        logic [35:0] d9;
        a10 = {1'b0, avg, 3'b000} + {3'b000, avg, 1'b0};
        d9  = {1'b0, des, 3'b000} + {4'b0000, des};
        if (a10 > d9) begin
            return ST_GREEN;
        end else if ({3'b000, avg, 1'b0} > {4'b0000, des}) begin
            return ST_YELLOW;
        end else begin
            return ST_RED;
        end
    endfunction

endpackage

// File: design/erm_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit divisor.
// No package dependencies.
module erm_div #(
    parameter int unsigned DIV_W = 52
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_num,
    input  logic [31:0]      i_den,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);

    localparam int unsigned CW = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DIV_W-1:0] r_num;
    logic [DIV_W-1:0] r_quot;
    logic [31:0]      r_rem;
    logic [31:0]      r_den;

    logic [32:0]      rem_sh;
    logic             ge;

    // trial subtract of the shifted partial remainder
    assign rem_sh = {r_rem, r_num[DIV_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[DIV_W-2:0], 1'b0};
            r_quot <= {r_quot[DIV_W-2:0], ge};
            r_rem  <= ge ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: design/erm_ring.sv
// Ring of recent rates: one write port, one read port, registered read data.
// No package dependencies.
module erm_ring #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    // write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/event_rate_monitor.sv
// Top level of the event rate monitor: sample sequencer, counters, window sum.
// Depends on erm_pkg, erm_div and erm_ring.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------
//  in       | input     | i_in_valid / o_in_stall  | i_op, i_timestamp
//  out      | output    | o_out_valid / i_out_stall| o_mean_rate, o_status
//  cfg      | input     | i_cfg_we                 | i_cfg_data
//
// An event does not stall the input. A sample holds the input while the sequencer
// forms the count product, runs the bit-serial rate divider, updates the window
// sum, takes the window average (two 16-bit digits by reciprocal multiply) and
// the status, and loads the output. A zero-interval sample goes straight to output.
// Reset is synchronous; the ring is tracked by a fill count, so no clearing pass.
// The input stalls while a sample is in work; a waiting result holds the
// sequencer only at its last step.
module event_rate_monitor
    import erm_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [31:0] i_timestamp,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_mean_rate,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);

    localparam int unsigned PW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int unsigned FW     = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned SUM_W  = 32 + $clog2(WINDOW_DEPTH);
    localparam int unsigned PROD_W = COUNT_WIDTH + Q8_W;
    localparam int unsigned DIV_W  = PROD_W;

    // window average: sum / WINDOW_DEPTH in two 16-bit digits, each by
    // multiplying with a rounded-up reciprocal of the depth
    localparam int unsigned     AVG_L   = $clog2(WINDOW_DEPTH);
    localparam int unsigned     AVG_XW  = 16 + AVG_L;
    localparam int unsigned     AVG_MW  = AVG_XW + 1;
    localparam int unsigned     AVG_K   = AVG_XW + AVG_L;
    localparam int unsigned     AVG_PW  = AVG_XW + AVG_MW;
    localparam longint unsigned AVG_M   =
        ((64'd1 << AVG_K) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
    localparam logic [AVG_MW-1:0] AVG_MUL = AVG_MW'(AVG_M);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_RATE_GO,
        S_RATE_WAIT,
        S_SUM,
        S_AVG_HI,
        S_AVG_HQ,
        S_AVG_LO,
        S_AVG_LQ,
        S_STATUS,
        S_DONE
    } t_state;

    t_state                 r_state, n_state;
    logic [31:0]            r_desired, n_desired;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [31:0]            r_last_time, n_last_time;
    logic [PW-1:0]          r_pos, n_pos;
    logic [FW-1:0]          r_fill, n_fill;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic                   r_out_valid, n_out_valid;

    // payload registers
    logic [31:0]            r_ts, n_ts;
    logic [31:0]            r_interval, n_interval;
    logic [PROD_W-1:0]      r_product, n_product;
    logic [31:0]            r_rate, n_rate;
    logic [31:0]            r_avg, n_avg;
    t_status                r_res_status, n_res_status;
    logic [31:0]            r_out_avg, n_out_avg;
    t_status                r_out_status, n_out_status;
    logic [AVG_XW-1:0]      r_avg_x, n_avg_x;
    logic [AVG_PW-1:0]      r_avg_prod, n_avg_prod;
    logic [15:0]            r_avg_qhi, n_avg_qhi;
    logic [AVG_XW-1:0]      r_avg_rem, n_avg_rem;

    logic                   in_xfer;
    logic                   div_start;
    logic [DIV_W-1:0]       div_num;
    logic [31:0]            div_den;
    logic                   div_done;
    logic [DIV_W-1:0]       div_quot;
    logic                   ring_we;
    logic                   ring_re;
    logic [31:0]            ring_rdata;
    logic [31:0]            old_rate;
    logic                   ring_full;
    logic [15:0]            avg_digit;
    logic [AVG_XW-1:0]      avg_digit_mul;
    logic [AVG_XW-1:0]      avg_x_lo;

    assign in_xfer   = i_in_valid && (r_state == S_IDLE);
    assign ring_full = (r_fill == FW'(WINDOW_DEPTH));
    // entries not yet written since reset read as zero
    assign old_rate  = ring_full ? ring_rdata : 32'd0;

    // divider for the rate only
    assign div_start = (r_state == S_RATE_GO);
    assign div_num   = DIV_W'(r_product);
    assign div_den   = r_interval;

    assign ring_re = (r_state == S_MUL);
    assign ring_we = (r_state == S_SUM);

    // quotient digit, its multiple of the depth, and the low-digit dividend
    assign avg_digit     = r_avg_prod[AVG_K +: 16];
    assign avg_digit_mul = AVG_XW'(avg_digit) * AVG_XW'(WINDOW_DEPTH);
    assign avg_x_lo      = (r_avg_rem << 16) | AVG_XW'(r_sum[15:0]);

    erm_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    erm_ring #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (PW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_pos),
        .i_wdata (r_rate),
        .i_re    (ring_re),
        .i_raddr (r_pos),
        .o_rdata (ring_rdata)
    );

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_desired    = r_desired;
        n_count      = r_count;
        n_last_time  = r_last_time;
        n_pos        = r_pos;
        n_fill       = r_fill;
        n_sum        = r_sum;
        n_out_valid  = r_out_valid;
        n_ts         = r_ts;
        n_interval   = r_interval;
        n_product    = r_product;
        n_rate       = r_rate;
        n_avg        = r_avg;
        n_res_status = r_res_status;
        n_out_avg    = r_out_avg;
        n_out_status = r_out_status;
        n_avg_x      = r_avg_x;
        n_avg_prod   = r_avg_prod;
        n_avg_qhi    = r_avg_qhi;
        n_avg_rem    = r_avg_rem;

        if (i_cfg_we) begin
            n_desired = i_cfg_data;
        end
        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (!i_op) begin
                        if (r_count != '1) begin
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        n_ts       = i_timestamp;
                        n_interval = i_timestamp - r_last_time;
                        if (i_timestamp == r_last_time) begin
                            // zero interval: zero average, red; window, count and last time stay
                            n_avg        = 32'd0;
                            n_res_status = ST_RED;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_MUL;
                        end
                    end
                end
            end
            S_MUL: begin
                n_product = PROD_W'(r_count) * PROD_W'(US_Q8);
                n_state   = S_RATE_GO;
            end
            S_RATE_GO: begin
                n_state = S_RATE_WAIT;
            end
            S_RATE_WAIT: begin
                if (div_done) begin
                    n_rate  = (|div_quot[DIV_W-1:32]) ? 32'hFFFF_FFFF : div_quot[31:0];
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_sum       = r_sum - SUM_W'(old_rate) + SUM_W'(r_rate);
                n_pos       = (r_pos == PW'(WINDOW_DEPTH - 1)) ? '0 : r_pos + 1'b1;
                n_fill      = ring_full ? r_fill : r_fill + 1'b1;
                n_last_time = r_ts;
                n_count     = '0;
                n_state     = S_AVG_HI;
            end
            // high digit: upper sum bits times the reciprocal
            S_AVG_HI: begin
                n_avg_x    = r_sum[SUM_W-1:16];
                n_avg_prod = AVG_PW'(r_sum[SUM_W-1:16]) * AVG_PW'(AVG_MUL);
                n_state    = S_AVG_HQ;
            end
            S_AVG_HQ: begin
                n_avg_qhi = avg_digit;
                n_avg_rem = r_avg_x - avg_digit_mul;
                n_state   = S_AVG_LO;
            end
            // low digit: remainder joined with the lower sum bits
            S_AVG_LO: begin
                n_avg_x    = avg_x_lo;
                n_avg_prod = AVG_PW'(avg_x_lo) * AVG_PW'(AVG_MUL);
                n_state    = S_AVG_LQ;
            end
            S_AVG_LQ: begin
                n_avg   = {r_avg_qhi, avg_digit};
                n_state = S_STATUS;
            end
            S_STATUS: begin
                n_res_status = status_of(r_avg, r_desired);
                n_state      = S_DONE;
            end
            S_DONE: begin
                // load the output register once it is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_avg    = r_avg;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        r_ts         <= n_ts;
        r_interval   <= n_interval;
        r_product    <= n_product;
        r_rate       <= n_rate;
        r_avg        <= n_avg;
        r_res_status <= n_res_status;
        r_out_avg    <= n_out_avg;
        r_out_status <= n_out_status;
        r_avg_x      <= n_avg_x;
        r_avg_prod   <= n_avg_prod;
        r_avg_qhi    <= n_avg_qhi;
        r_avg_rem    <= n_avg_rem;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_desired   <= '0;
            r_count     <= '0;
            r_last_time <= '0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_desired   <= n_desired;
            r_count     <= n_count;
            r_last_time <= n_last_time;
            r_pos       <= n_pos;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_mean_rate = r_out_avg;
    assign o_status    = r_out_status;

endmodule

// File: design/erm_checker.sv
// Port-level checks for event_rate_monitor, bound to the top level.
// Depends on erm_pkg.
module erm_checker
    import erm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_op,
    input logic [31:0] i_timestamp,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_mean_rate,
    input logic [1:0]  o_status,
    input logic        i_cfg_we,
    input logic [31:0] i_cfg_data
);

    // reset leaves no result pending and the input open
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result or stall left over after reset");

    // a sample transfer occupies the block for at least the next cycle
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_in_valid && !o_in_stall && i_op |=> o_in_stall)
        else $error("input open right after a sample transfer");

    // a zero average can never beat a threshold
    a_zero_is_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_mean_rate == 32'd0) |-> (o_status == ST_RED))
        else $error("zero average not classified red");

    // green needs a nonzero average
    a_green_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_GREEN) |-> (o_mean_rate != 32'd0))
        else $error("green status with zero average");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_mean_rate) && $stable(o_status))
        else $error("stalled result changed");

endmodule

bind event_rate_monitor erm_checker u_erm_checker (.*);

// File: tb/event_rate_monitor_tb.sv
// Self-checking testbench for event_rate_monitor: a directed table, then random
// event bursts and samples under several target rates, checked by a rate predictor.
// Depends on erm_pkg and the event_rate_monitor RTL.
`timescale 1ns / 1ps

module event_rate_monitor_tb;
    import erm_pkg::*;

    localparam int unsigned DEPTH        = WINDOW_DEPTH_DEF;
    localparam int unsigned CW           = COUNT_WIDTH_DEF;
    localparam logic [63:0] US_SCALE     = 64'd256_000_000;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned PHASE_ITEMS  = 240;
    localparam int unsigned CALM_PHASE   = 4;
    localparam int unsigned CFG_SETTLE   = 8;
    localparam int unsigned DRAIN_CYCLES = 120;
    localparam int unsigned QUIET_LIMIT  = 5000;

    typedef struct packed {
        logic [31:0] avg;
        t_status     st;
    } t_rate_result;

    typedef struct {
        logic         op;
        logic [31:0]  ts;
        int unsigned  reps;
        bit           fixed_exp;
        t_rate_result res;
    } t_stim_row;

    // DUT ports
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic        i_op        = 1'b0;
    logic [31:0] i_timestamp = 32'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_mean_rate;
    logic [1:0]  o_status;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_data  = 32'd0;

    // Predictor state
    logic [31:0]   want_rate = 32'd0;
    logic [CW-1:0] ev_count  = '0;
    logic [31:0]   last_ts   = 32'd0;
    logic [31:0]   ring [DEPTH];
    int unsigned   ring_pos  = 0;
    logic [35:0]   win_sum   = '0;

    t_rate_result  avg_q [$];
    int unsigned   fail_count   = 0;
    int unsigned   quiet_cycles = 0;
    bit            calm         = 1'b0;

    // Directed part: zero interval, full-rate saturation, timestamp wrap, held count
    t_stim_row plan [9] = '{
        '{1'b1, 32'd0,          1,  1'b1, '{32'd0,          ST_RED}},
        '{1'b0, 32'hFFFF_FFFF,  17, 1'b0, '{32'd0,          ST_RED}},
        '{1'b1, 32'd1,          1,  1'b1, '{32'h0FFF_FFFF,  ST_GREEN}},
        '{1'b1, 32'hFFFF_FFFF,  1,  1'b0, '{32'd0,          ST_RED}},
        '{1'b0, 32'd0,          1,  1'b0, '{32'd0,          ST_RED}},
        '{1'b1, 32'd5,          1,  1'b0, '{32'd0,          ST_RED}},
        '{1'b0, 32'h5555_5555,  1,  1'b0, '{32'd0,          ST_RED}},
        '{1'b1, 32'd5,          1,  1'b1, '{32'd0,          ST_RED}},
        '{1'b1, 32'd7,          1,  1'b0, '{32'd0,          ST_RED}}
    };

    event_rate_monitor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_timestamp (i_timestamp),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_mean_rate (o_mean_rate),
        .o_status    (o_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            ring[i] = 32'd0;
        end
    end

    // Status band of an average against the current target
    function automatic t_status rate_band(logic [31:0] avg);
        if (64'(avg) * 64'd10 > 64'(want_rate) * 64'd9) begin
            return ST_GREEN;
        end else if (64'(avg) * 64'd2 > 64'(want_rate)) begin
            return ST_YELLOW;
        end else begin
            return ST_RED;
        end
    endfunction

    // Advance the rate meter by one transfer; returns 1 when a result is due
    function automatic bit meter_step(input logic op, input logic [31:0] ts,
                                      output t_rate_result res);
        logic [31:0] gap;
        logic [63:0] quot;
        logic [31:0] rate;
        res = '{32'd0, ST_RED};
        if (op == 1'b0) begin
            if (ev_count != {CW{1'b1}}) begin
                ev_count = ev_count + 1'b1;
            end
            return 1'b0;
        end
        gap = ts - last_ts;
        // zero interval: red, nothing moves
        if (gap == 32'd0) begin
            return 1'b1;
        end
        quot = (64'(ev_count) * US_SCALE) / 64'(gap);
        rate = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
        win_sum = win_sum - 36'(ring[ring_pos]) + 36'(rate);
        ring[ring_pos] = rate;
        ring_pos = (ring_pos + 1) % DEPTH;
        last_ts  = ts;
        ev_count = '0;
        res.avg = 32'(win_sum / DEPTH);
        res.st  = rate_band(res.avg);
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH at %0t: %s got 0x%h want 0x%h", $time, what, got, want);
        fail_count++;
    endtask

    // One input transfer, with random idle cycles ahead of it
    task automatic send_item(input logic op, input logic [31:0] ts,
                             input bit fixed_exp, input t_rate_result fixed_res);
        t_rate_result res;
        bit           due;
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 7) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_timestamp <= ts;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        due = meter_step(op, ts, res);
        if (due) begin
            avg_q.push_back(fixed_exp ? fixed_res : res);
        end
    endtask

    // Program the target rate once the block has gone quiet
    task automatic set_target_rate(input logic [31:0] value);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (avg_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (CFG_SETTLE) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        want_rate  = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Receiver: random stall, none during the calm phase
    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 7);
    end

    // Result checker
    always @(posedge i_clk) begin
        t_rate_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (avg_q.size() == 0) begin
                flag_mismatch("unexpected result", o_mean_rate, 32'd0);
            end else begin
                want = avg_q.pop_front();
                if (o_mean_rate !== want.avg) begin
                    flag_mismatch("mean_rate", o_mean_rate, want.avg);
                end
                if (o_status !== want.st) begin
                    flag_mismatch("status", 32'(o_status), 32'(want.st));
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        logic [31:0] gap;
        logic [63:0] scaled;
        int unsigned pick;
        int unsigned burst;
        int unsigned phase_items;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            repeat (plan[r].reps) begin
                send_item(plan[r].op, plan[r].ts, plan[r].fixed_exp, plan[r].res);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            // target: both extremes, a random one, then 0.5x to 3x the current average (random if zero)
            scaled = 64'(win_sum / DEPTH) * 64'($urandom_range(4, 24)) / 64'd8;
            if (phase == 0) begin
                set_target_rate(32'hFFFF_FFFF);
            end else if (phase == 1) begin
                set_target_rate(32'd0);
            end else if (phase == 2 || scaled == 64'd0) begin
                set_target_rate($urandom);
            end else begin
                set_target_rate(scaled > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : scaled[31:0]);
            end

            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                // event burst, now and then a long one to push the rate to saturation
                burst = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
                repeat (burst) begin
                    send_item(1'b0, $urandom, 1'b0, '0);
                    calm = (phase == CALM_PHASE);
                end
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    gap = 32'd0;
                end else if (pick < 15) begin
                    gap = $urandom;
                end else if (pick < 35) begin
                    gap = $urandom_range(1, 64);
                end else begin
                    gap = $urandom_range(1000, 2_000_000);
                end
                send_item(1'b1, last_ts + gap, 1'b0, '0);
                calm = (phase == CALM_PHASE);
                phase_items += burst + 1;
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (avg_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (avg_q.size() != 0) begin
            flag_mismatch("results never delivered", 32'(avg_q.size()), 32'd0);
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
